### rtl/hex_text_to_bytes_parser_core_assert.svh
// Assertion helpers for the hex text parser, clocked on clk_i, off while in reset.
`ifndef HEX_TEXT_TO_BYTES_PARSER_CORE_ASSERT_SVH
`define HEX_TEXT_TO_BYTES_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HXP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hex parser check failed");

// Next-cycle implication.
`define HXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hex parser check failed");

`endif

### rtl/hxp_pkg.sv
`timescale 1ns / 1ps

package hxp_pkg;

  typedef enum logic [1:0] {
    ModeSearch = 2'd0,
    ModeAngle  = 2'd1,
    ModeBrace  = 2'd2,
    ModeDone   = 2'd3
  } mode_e;

  localparam logic OpChar = 1'b0;
  localparam logic OpEnd  = 1'b1;

  localparam logic KindData   = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam logic [7:0] ChAngleOpen  = 8'h3C;  // '<'
  localparam logic [7:0] ChAngleClose = 8'h3E;  // '>'
  localparam logic [7:0] ChBraceOpen  = 8'h7B;  // '{'
  localparam logic [7:0] ChBraceClose = 8'h7D;  // '}'
  localparam logic [7:0] ChZero       = 8'h30;  // '0'
  localparam logic [7:0] ChLowerX     = 8'h78;  // 'x'
  localparam logic [7:0] ChUpperX     = 8'h58;  // 'X'
  localparam logic [7:0] ChNine       = 8'h39;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerF     = 8'h66;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperF     = 8'h46;
  localparam logic [3:0] NibbleTen    = 4'ha;

  // min(COUNT_MAX, 65535) with COUNT_MAX = 65535
  localparam logic [15:0] CountLimit = 16'hFFFF;

  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = PtrW + 1;

  typedef struct packed {
    logic        lo_next;
    logic [3:0]  high;
    logic [15:0] count;
  } nib_t;

  typedef struct packed {
    nib_t       st;
    logic       emit;
    logic [7:0] data;
  } feed_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] count;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= ChZero && c <= ChNine) begin
      r = {1'b1, c[3:0]};
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      r = {1'b1, 4'(c - ChLowerA) + NibbleTen};
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      r = {1'b1, 4'(c - ChUpperA) + NibbleTen};
    end
    return r;
  endfunction

  function automatic feed_t feed(input nib_t s, input logic [4:0] dig);
    feed_t f;
    f.st   = s;
    f.emit = 1'b0;
    f.data = 8'd0;
    if (dig[4]) begin
      if (s.lo_next) begin
        f.emit       = 1'b1;
        f.data       = {s.high, dig[3:0]};
        f.st.lo_next = 1'b0;
        if (s.count != CountLimit) begin
          f.st.count = s.count + 16'd1;
        end
      end else begin
        f.st.high    = dig[3:0];
        f.st.lo_next = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

### rtl/hex_text_to_bytes_parser_core.sv
`timescale 1ns / 1ps
`include "hex_text_to_bytes_parser_core_assert.svh"

// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | opcode_i, text_char_i
// out     | out_valid_o | out_stall_i | result_kind_o, data_byte_o, byte_count_o
//
// One character per cycle while in_stall_o is low: an item is registered, decoded
// in one pass against the parser state and its 0..2 results land in an 8-entry
// result queue. The stage register and the queue count lie between accept and valid.
// Input stalls unless the queue can reserve two slots for the staged item and two more.
// Reset clears parser state, the stage valid and the queue pointers.
module hex_text_to_bytes_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  text_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_count_o
);
  import hxp_pkg::*;

  localparam logic [CntW-1:0] DepthCnt = CntW'(FifoDepth);

  logic            stg_vld_q;
  logic            stg_op_q;
  logic [7:0]      stg_char_q;
  logic            in_acc;

  mode_e           mode_q, mode_d;
  nib_t            nib_q, nib_d;
  logic            zero_held_q, zero_held_d;
  logic            take_raw_q, take_raw_d;

  logic [4:0]      dig1, dig2;
  logic [4:0]      char_dig;
  logic            prefix_skip;
  feed_t           f1, f2;
  logic            data_v;
  logic [7:0]      data_b;
  result_t         r0, r1;
  logic [1:0]      n_push;

  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] reserve;
  logic            pop;

  // slots already owed to the queue, plus two for a new item
  assign reserve    = cnt_q + (stg_vld_q ? CntW'(2) : CntW'(0));
  assign in_stall_o = (reserve + CntW'(2)) > DepthCnt;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else begin
      stg_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_op_q   <= opcode_i;
      stg_char_q <= text_char_i;
    end
  end

  assign char_dig = hex_digit(stg_char_q);

  always_comb begin
    mode_d      = mode_q;
    zero_held_d = zero_held_q;
    take_raw_d  = take_raw_q;
    dig1        = 5'd0;
    dig2        = 5'd0;
    prefix_skip = 1'b0;
    if (stg_op_q == OpEnd) begin
      if (mode_q == ModeBrace && zero_held_q) begin
        dig1 = {1'b1, 4'd0};
      end
    end else begin
      case (mode_q)
        ModeSearch: begin
          if (stg_char_q == ChAngleOpen) begin
            mode_d = ModeAngle;
          end else if (stg_char_q == ChBraceOpen) begin
            mode_d = ModeBrace;
          end
        end
        ModeAngle: begin
          if (stg_char_q == ChAngleClose) begin
            mode_d = ModeDone;
          end else begin
            dig1 = char_dig;
          end
        end
        ModeBrace: begin
          if (take_raw_q) begin
            take_raw_d = 1'b0;
            dig1       = char_dig;
          end else begin
            if (zero_held_q) begin
              zero_held_d = 1'b0;
              if (stg_char_q == ChLowerX || stg_char_q == ChUpperX) begin
                take_raw_d  = 1'b1;
                prefix_skip = 1'b1;
              end else begin
                dig1 = {1'b1, 4'd0};
              end
            end
            if (!prefix_skip) begin
              if (stg_char_q == ChBraceClose) begin
                mode_d = ModeDone;
              end else if (stg_char_q == ChZero) begin
                zero_held_d = 1'b1;
              end else begin
                dig2 = char_dig;
              end
            end
          end
        end
        default: ;
      endcase
    end

    f1    = feed(nib_q, dig1);
    f2    = feed(f1.st, dig2);
    nib_d = f2.st;

    // a character step yields at most one byte
    data_v = f1.emit || f2.emit;
    data_b = f1.emit ? f1.data : f2.data;

    r0 = '{kind: KindData, data: data_b, count: 16'd0};
    r1 = '{kind: KindReport, data: 8'd0, count: f2.st.count};
    n_push = {1'b0, data_v};

    if (stg_op_q == OpEnd) begin
      n_push = data_v ? 2'd2 : 2'd1;
      if (!data_v) begin
        r0 = r1;
      end
      mode_d      = ModeSearch;
      nib_d       = '0;
      zero_held_d = 1'b0;
      take_raw_d  = 1'b0;
    end

    if (!stg_vld_q) begin
      n_push = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeSearch;
      nib_q       <= '0;
      zero_held_q <= 1'b0;
      take_raw_q  <= 1'b0;
    end else if (stg_vld_q) begin
      mode_q      <= mode_d;
      nib_q       <= nib_d;
      zero_held_q <= zero_held_d;
      take_raw_q  <= take_raw_d;
    end
  end

  // result queue
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_d       = cnt_q + CntW'(n_push) - (pop ? CntW'(1) : CntW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + (pop ? PtrW'(1) : PtrW'(0));
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= r1;
    end
  end

  assign result_kind_o = fifo_q[rd_ptr_q].kind;
  assign data_byte_o   = fifo_q[rd_ptr_q].data;
  assign byte_count_o  = fifo_q[rd_ptr_q].count;

  `HXP_ASSERT_NOW(a_queue_room, stg_vld_q, (cnt_q + CntW'(2)) <= DepthCnt)
  `HXP_ASSERT_NOW(a_zero_in_brace, zero_held_q, mode_q == ModeBrace)
  `HXP_ASSERT_NOW(a_raw_excl, take_raw_q, (mode_q == ModeBrace) && !zero_held_q)
  `HXP_ASSERT_NEXT(a_end_resets, stg_vld_q && (stg_op_q == OpEnd),
                   (mode_q == ModeSearch) && (nib_q == '0) && (cnt_q != '0))

endmodule

### tb/sv/hex_decode_sb_pkg.sv
`timescale 1ns / 1ps

package hex_decode_sb_pkg;
  import hxp_pkg::*;

  // Tracks the parser state on its own and holds the bytes and reports it still owes.
  class hex_decode_sb;
    mode_e       mode;
    bit          lo_next;
    bit [3:0]    high_nib;
    bit          zero_held;
    bit          raw_next;
    bit [15:0]   n_bytes;
    result_t     decoded_q[$];
    int unsigned mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      mode      = ModeSearch;
      lo_next   = 1'b0;
      high_nib  = 4'd0;
      zero_held = 1'b0;
      raw_next  = 1'b0;
      n_bytes   = 16'd0;
    endfunction

    // -1 when the character is not a hex digit
    function int nibble_of(bit [7:0] ch);
      if (ch >= ChZero && ch <= ChNine) return int'(ch) - int'(ChZero);
      if (ch >= ChLowerA && ch <= ChLowerF) return int'(ch) - int'(ChLowerA) + int'(NibbleTen);
      if (ch >= ChUpperA && ch <= ChUpperF) return int'(ch) - int'(ChUpperA) + int'(NibbleTen);
      return -1;
    endfunction

    function void take_digit(bit [7:0] ch);
      int v;
      v = nibble_of(ch);
      if (v < 0) return;
      if (lo_next) begin
        decoded_q.push_back('{kind: KindData, data: {high_nib, 4'(v)}, count: 16'd0});
        if (n_bytes != CountLimit) n_bytes++;
        lo_next = 1'b0;
      end else begin
        high_nib = 4'(v);
        lo_next  = 1'b1;
      end
    endfunction

    function void brace_char(bit [7:0] ch);
      // character after a skipped prefix: digit test only, never a marker
      if (raw_next) begin
        raw_next = 1'b0;
        take_digit(ch);
        return;
      end
      if (zero_held) begin
        zero_held = 1'b0;
        if (ch == ChLowerX || ch == ChUpperX) begin
          raw_next = 1'b1;
          return;
        end
        take_digit(ChZero);
      end
      if (ch == ChBraceClose) mode = ModeDone;
      else if (ch == ChZero) zero_held = 1'b1;
      else take_digit(ch);
    endfunction

    function void predict_item(bit op, bit [7:0] ch);
      if (op == OpEnd) begin
        if (mode == ModeBrace && zero_held) begin
          zero_held = 1'b0;
          take_digit(ChZero);
        end
        decoded_q.push_back('{kind: KindReport, data: 8'd0, count: n_bytes});
        clear_state();
        return;
      end
      case (mode)
        ModeSearch: begin
          if (ch == ChAngleOpen) mode = ModeAngle;
          else if (ch == ChBraceOpen) mode = ModeBrace;
        end
        ModeAngle: begin
          if (ch == ChAngleClose) mode = ModeDone;
          else take_digit(ch);
        end
        ModeBrace: brace_char(ch);
        default: ;
      endcase
    endfunction

    function void check_result(bit kind, bit [7:0] data, bit [15:0] count);
      result_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%02h count=%0d", kind, data, count);
        return;
      end
      want = decoded_q.pop_front();
      if (want.kind != kind || want.data != data || want.count != count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind=%0d data=%02h count=%0d, got kind=%0d data=%02h count=%0d",
                   want.kind, want.data, want.count, kind, data, count);
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hxp_pkg::*;
  import hex_decode_sb_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [7:0]  text_char_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        result_kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] byte_count_o;

  hex_decode_sb sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int items_sent = 0;

  hex_text_to_bytes_parser_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .text_char_i  (text_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .data_byte_o  (data_byte_o),
    .byte_count_o (byte_count_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(result_kind_o, data_byte_o, byte_count_o);
  end

  // receiver: random stall before each result, none while rx_idle is off
  initial begin
    int gap;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  function automatic bit [7:0] any_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic send_item(bit op, bit [7:0] ch);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    text_char_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_item(op, ch);
    items_sent++;
  endtask

  task automatic send_char(bit [7:0] ch);
    send_item(OpChar, ch);
  endtask

  task automatic send_end();
    send_item(OpEnd, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_token();
    int pick;
    bit [7:0] raw;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: send_char(any_hex());
      5: begin
        // prefix, then a raw character that may look like a marker or a zero
        case ($urandom_range(0, 3))
          0: raw = any_hex();
          1: raw = ChBraceClose;
          2: raw = ChZero;
          default: raw = 8'($urandom_range(0, 255));
        endcase
        send_char(ChZero);
        send_char($urandom_range(0, 1) ? ChLowerX : ChUpperX);
        send_char(raw);
      end
      6: begin
        send_char(ChZero);
        send_char(8'($urandom_range(0, 255)));
      end
      7: send_char(8'($urandom_range(0, 255)));
      8: send_char(ChZero);
      default: send_char(8'h2C);
    endcase
  endtask

  task automatic send_frame();
    int pick;
    bit angle;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      repeat ($urandom_range(1, 6))
        send_item($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      return;
    end
    angle = $urandom_range(0, 1);
    repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
    send_char(angle ? ChAngleOpen : ChBraceOpen);
    repeat ($urandom_range(0, 16)) send_token();
    if (pick < 75) begin
      send_char(angle ? ChAngleClose : ChBraceClose);
      repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1)) begin
      // text cut off on a held zero or inside a prefix
      send_char(ChZero);
      if ($urandom_range(0, 1)) send_char(ChUpperX);
    end
    send_end();
  endtask

  initial begin
    int first;
    in_valid_i  <= 1'b0;
    opcode_i    <= OpChar;
    text_char_i <= 8'd0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no marker at all, then angle digits at the range edges with junk after close
    send_item(OpEnd, 8'hFF);
    send_text("<09aF/:G>1");
    send_end();
    // brace: prefix with raw close, prefix with raw zero, held zero before close
    send_text("{0x}10X0070}");
    send_end();
    wait_drained();

    first = items_sent;
    while (items_sent - first < 900) begin
      if ($urandom_range(0, 7) == 0) tx_idle = ~tx_idle;
      if ($urandom_range(0, 7) == 0) rx_idle = ~rx_idle;
      if ($urandom_range(0, 24) == 0) wait_drained();
      send_frame();
    end
    send_end();

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
